// File: sv/double_column_type_profiler_top_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include guard below.
`ifndef DOUBLE_COLUMN_TYPE_PROFILER_TOP_MACROS_SVH
`define DOUBLE_COLUMN_TYPE_PROFILER_TOP_MACROS_SVH
// Implication checked on every edge outside reset.
`define DCTP_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication.
`define DCTP_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// File: sv/dctp_pkg.sv
// Package for the double column type profiler: constants, class struct and order-key helper.
// No dependencies.
package dctp_pkg;
  localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
  localparam logic [10:0] EXP_BIAS     = 11'd1023;
  localparam logic [10:0] EXP_WHOLE    = 11'd1075;

  typedef struct packed {
    logic        is_nan;
    logic        is_inf;
    logic        is_whole;
    logic        is_bool;
    logic [63:0] key;
  } dctp_class_t;

  // Numeric order key; both zeros map to the same key.
  function automatic logic [63:0] order_key(input logic [63:0] b);
    logic [63:0] k;
    if (b[62:0] == 63'd0) k = {1'b1, 63'd0};
    else if (b[63]) k = ~b;
    else k = {1'b1, b[62:0]};
    return k;
  endfunction
endpackage

// File: sv/double_column_type_profiler_top.sv
// Top level of the double column type profiler.
// Depends on dctp_pkg, dctp_classify and dctp_accum.
//
// Streams a column of binary64 values, one item per cycle, and on the item
// flagged last emits one result: any-value, any-infinity, all-integer,
// all-boolean, and the bit patterns of the smallest and largest finite values
// (+inf / -inf if none). NaNs of any payload are skipped. An accepted item is
// classified while it sits in the input register, and the key compares and
// flag update are registered in the profile registers when it advances;
// out_valid is registered when the last item of a column advances. The block
// takes one item per cycle, with one key compare each against the running min
// and max. The input stalls only when a last item meets a result still held by
// out_stall; that last item then waits in the input register.
module double_column_type_profiler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value_bits,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_any_value,
  output logic        out_any_inf,
  output logic        out_all_integer,
  output logic        out_all_boolean,
  output logic [63:0] out_min_bits,
  output logic [63:0] out_max_bits
);
  import dctp_pkg::*;
  logic        adv, s_valid, s_last;
  logic [63:0] s_value;
  dctp_class_t s_cls;

  // Register and classify the incoming item.
  dctp_classify u_cls (
    .clk, .rst_n, .in_valid, .in_stall, .in_value_bits, .in_last,
    .adv, .s_valid, .s_last, .s_value, .s_cls
  );

  // Fold it into the running profile; emit on last.
  dctp_accum u_acc (
    .clk, .rst_n, .s_valid, .s_last, .s_value, .s_cls, .adv,
    .out_valid, .out_stall, .out_any_value, .out_any_inf,
    .out_all_integer, .out_all_boolean, .out_min_bits, .out_max_bits
  );
endmodule

// File: sv/dctp_classify.sv
// Input register stage plus element classification.
// Depends on dctp_pkg.
module dctp_classify (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_value_bits,
  input  logic                 in_last,
  input  logic                 adv,
  output logic                 s_valid,
  output logic                 s_last,
  output logic [63:0]          s_value,
  output dctp_pkg::dctp_class_t s_cls
);
  import dctp_pkg::*;
  logic        valid_r;
  logic        last_r;
  logic [63:0] value_r;
  logic [10:0] ef;
  logic [51:0] fmask;
  logic [5:0]  fbits;

  assign in_stall = valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      value_r <= in_value_bits;
      last_r  <= in_last;
    end
  end

  assign ef    = value_r[62:52];
  assign fbits = 6'(EXP_WHOLE - ef);
  assign fmask = ~(52'hF_FFFF_FFFF_FFFF << fbits);

  always_comb begin
    s_cls.is_nan = (ef == 11'h7FF) && (value_r[51:0] != 52'd0);
    s_cls.is_inf = (ef == 11'h7FF) && (value_r[51:0] == 52'd0);
    s_cls.is_bool = (value_r[62:0] == 63'd0) || (value_r == ONE_BITS);
    if (value_r[62:0] == 63'd0) s_cls.is_whole = 1'b1;
    else if (ef < EXP_BIAS) s_cls.is_whole = 1'b0;
    else if (ef >= EXP_WHOLE) s_cls.is_whole = 1'b1;
    else s_cls.is_whole = (value_r[51:0] & fmask) == 52'd0;
    s_cls.key = order_key(value_r);
  end

  assign s_valid = valid_r;
  assign s_last  = last_r;
  assign s_value = value_r;
endmodule

// File: sv/dctp_accum.sv
// Running profile state and result register.
// Depends on dctp_pkg.
module dctp_accum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s_valid,
  input  logic                  s_last,
  input  logic [63:0]           s_value,
  input  dctp_pkg::dctp_class_t s_cls,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_any_value,
  output logic                  out_any_inf,
  output logic                  out_all_integer,
  output logic                  out_all_boolean,
  output logic [63:0]           out_min_bits,
  output logic [63:0]           out_max_bits
);
  import dctp_pkg::*;
  logic seen_r, seen_nxt, nonfin_r, nonfin_nxt, int_r, int_nxt, bool_r, bool_nxt;
  logic [63:0] min_r, min_nxt, max_r, max_nxt, mink_r, mink_nxt, maxk_r, maxk_nxt;
  logic ovalid_r, ovalid_nxt;
  logic fire;
  logic res_value_r, res_inf_r, res_int_r, res_bool_r;
  logic [63:0] res_min_r, res_max_r;

  // Advance unless a result would overwrite one still waiting.
  assign adv = !(ovalid_r && out_stall && s_last);
  assign fire = s_valid && adv && s_last;
  assign ovalid_nxt = fire || (ovalid_r && out_stall);

  always_comb begin
    seen_nxt = seen_r; nonfin_nxt = nonfin_r; int_nxt = int_r; bool_nxt = bool_r;
    min_nxt = min_r; max_nxt = max_r; mink_nxt = mink_r; maxk_nxt = maxk_r;
    if (!s_cls.is_nan) begin
      seen_nxt = 1'b1;
      if (s_cls.is_inf) begin
        nonfin_nxt = 1'b1; int_nxt = 1'b0; bool_nxt = 1'b0;
      end else begin
        if (s_cls.key < mink_r) begin
          min_nxt = s_value; mink_nxt = s_cls.key;
        end
        if (s_cls.key > maxk_r) begin
          max_nxt = s_value; maxk_nxt = s_cls.key;
        end
        if (!s_cls.is_bool) bool_nxt = 1'b0;
        if (!s_cls.is_whole) int_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      seen_r <= 1'b0; nonfin_r <= 1'b0; int_r <= 1'b1; bool_r <= 1'b1;
      min_r <= POS_INF_BITS; max_r <= NEG_INF_BITS;
      mink_r <= order_key(POS_INF_BITS); maxk_r <= order_key(NEG_INF_BITS);
    end else begin
      ovalid_r <= ovalid_nxt;
      if (fire) begin
        res_value_r <= seen_nxt; res_inf_r <= nonfin_nxt;
        res_int_r <= int_nxt; res_bool_r <= bool_nxt;
        res_min_r <= min_nxt; res_max_r <= max_nxt;
        seen_r <= 1'b0; nonfin_r <= 1'b0; int_r <= 1'b1; bool_r <= 1'b1;
        min_r <= POS_INF_BITS; max_r <= NEG_INF_BITS;
        mink_r <= order_key(POS_INF_BITS); maxk_r <= order_key(NEG_INF_BITS);
      end else if (s_valid && adv) begin
        seen_r <= seen_nxt; nonfin_r <= nonfin_nxt; int_r <= int_nxt;
        bool_r <= bool_nxt; min_r <= min_nxt; max_r <= max_nxt;
        mink_r <= mink_nxt; maxk_r <= maxk_nxt;
      end
    end
  end

  assign out_valid       = ovalid_r;
  assign out_any_value   = res_value_r;
  assign out_any_inf     = res_inf_r;
  assign out_all_integer = res_int_r;
  assign out_all_boolean = res_bool_r;
  assign out_min_bits    = res_min_r;
  assign out_max_bits    = res_max_r;
endmodule

// File: sv/dctp_checker.sv
// Port-level checker for the profiler top level, with its bind.
// Depends on the macros header.
`include "double_column_type_profiler_top_macros.svh"
module dctp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_any_value,
  input logic        out_any_inf,
  input logic        out_all_integer,
  input logic        out_all_boolean
);
  `DCTP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `DCTP_ASSERT_IMP(a_inf_flags, clk, rst_n, out_valid && out_any_inf,
    !out_all_integer && !out_all_boolean && out_any_value, "inf flags")
  `DCTP_ASSERT_IMP(a_bool_int, clk, rst_n, out_valid && out_all_boolean, out_all_integer,
    "boolean not integer")
  `DCTP_ASSERT_IMP(a_no_stall_idle, clk, rst_n, !out_valid, !in_stall,
    "stall without held result")
endmodule

bind double_column_type_profiler_top dctp_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_any_value, .out_any_inf, .out_all_integer, .out_all_boolean
);

// File: bench/tb.sv
// Testbench for the double column type profiler: drives columns of binary64
// items, predicts each column's profile and checks it. Depends on dctp_pkg.
`timescale 1ns / 1ps

class column_scoreboard;
  bit          seen_value;
  bit          seen_non_finite;
  bit          integer_so_far;
  bit          boolean_so_far;
  logic [63:0] running_min;
  logic [63:0] running_max;
  logic [3:0]  pending[$];
  logic [63:0] mins[$];
  logic [63:0] maxs[$];
  int          failures;

  function new();
    failures = 0;
    clear_profile();
  endfunction

  function void clear_profile();
    seen_value = 0;
    seen_non_finite = 0;
    integer_so_far = 1;
    boolean_so_far = 1;
    running_min = dctp_pkg::POS_INF_BITS;
    running_max = dctp_pkg::NEG_INF_BITS;
  endfunction

  function logic [63:0] numeric_key(logic [63:0] b);
    if (b[62:0] == 63'd0) return {1'b1, 63'd0};
    if (b[63]) return ~b;
    return {1'b1, b[62:0]};
  endfunction

  function bit whole_value(logic [63:0] b);
    logic [62:0] mag;
    int          e;
    logic [62:0] fmask;
    mag = b[62:0];
    if (mag == 63'd0) return 1;
    e = int'(mag[62:52]);
    if (e < 1023) return 0;
    if (e >= 1075) return 1;
    fmask = (63'd1 << (1075 - e)) - 63'd1;
    return (mag & fmask) == 63'd0;
  endfunction

  function void note_item(logic [63:0] v, bit last);
    bit all_ones;
    all_ones = v[62:52] == 11'h7FF;
    if (!(all_ones && v[51:0] != 52'd0)) begin
      seen_value = 1;
      if (all_ones) begin
        seen_non_finite = 1;
        integer_so_far = 0;
        boolean_so_far = 0;
      end else begin
        if (numeric_key(v) < numeric_key(running_min)) running_min = v;
        if (numeric_key(v) > numeric_key(running_max)) running_max = v;
        if (v[62:0] != 63'd0 && v != dctp_pkg::ONE_BITS) boolean_so_far = 0;
        if (!whole_value(v)) integer_so_far = 0;
      end
    end
    if (last) begin
      pending.push_back({seen_value, seen_non_finite, integer_so_far, boolean_so_far});
      mins.push_back(running_min);
      maxs.push_back(running_max);
      clear_profile();
    end
  endfunction

  function void check_result(bit hv, bit nf, bit ai, bit ab, logic [63:0] mn,
                             logic [63:0] mx);
    logic [3:0]  e;
    logic [63:0] emin;
    logic [63:0] emax;
    if (pending.size() == 0) begin
      $error("result with no column pending");
      failures++;
      return;
    end
    e = pending.pop_front();
    emin = mins.pop_front();
    emax = maxs.pop_front();
    if (hv !== e[3]) begin
      $error("any_value expected %0d actual %0d", e[3], hv); failures++;
    end
    if (nf !== e[2]) begin
      $error("any_inf expected %0d actual %0d", e[2], nf); failures++;
    end
    if (ai !== e[1]) begin
      $error("all_integer expected %0d actual %0d", e[1], ai); failures++;
    end
    if (ab !== e[0]) begin
      $error("all_boolean expected %0d actual %0d", e[0], ab); failures++;
    end
    if (mn !== emin) begin
      $error("min_bits expected %h actual %h", emin, mn); failures++;
    end
    if (mx !== emax) begin
      $error("max_bits expected %h actual %h", emax, mx); failures++;
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [63:0] in_value_bits = 0;
  logic        in_last = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_any_value, out_any_inf, out_all_integer, out_all_boolean;
  logic [63:0] out_min_bits, out_max_bits;

  column_scoreboard board;
  bit          hold_off_req = 0;  // ask the receiver for a long stall

  double_column_type_profiler_top u_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Send one item: hold it until accepted, optionally leave a gap after.
  task automatic send_item(logic [63:0] v, bit last, int gap);
    in_valid <= 1;
    in_value_bits <= v;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    board.note_item(v, last);
    if (gap > 0) begin
      in_valid <= 0;
      in_value_bits <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random element drawn mostly from interesting classes.
  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: return {r[63], 11'h7FF, r[51:0] | 52'd1};            // NaN, any payload
      1: return {r[63], 11'h7FF, 52'd0};                      // infinity
      2: return {r[63], 63'd0};                               // signed zero
      3: return dctp_pkg::ONE_BITS;
      4: return {r[63], 11'd0, r[51:0]};                      // subnormal
      5: return {r[63], 11'd1023 + 11'($urandom_range(0, 60)), r[51:0] &
                 ~((52'd1 << $urandom_range(0, 52)) - 52'd1)}; // often whole
      6: return {1'b0, 11'($urandom_range(1023, 1030)), 52'd0};// small positive ints
      7: return 64'h7FF8_0000_0000_07A2;                      // R's NA
      default: return r;
    endcase
  endfunction

  // Gap between items: bursts with no idling, then random gaps.
  int burst_left = 0;
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 30);
    return $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
  endfunction

  task automatic send_column(int len);
    for (int i = 0; i < len; i++) send_item(pick_value(), i == len - 1, next_gap());
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request.
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end
      phase++;
      case ((phase / 200) % 3)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Check each accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_any_value, out_any_inf, out_all_integer,
                         out_all_boolean, out_min_bits, out_max_bits);
  end

  initial begin
    int sent;
    bit hold_done;
    bit drained;
    board = new();
    hold_done = 0;
    drained = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, each class, ties between signed zeros, NaN on last.
    send_item(64'h7FF8_0000_0000_0001, 1, 0);          // column of one NaN
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_item(64'h7FF8_0000_0000_07A2, 1, 1);          // NaNs only
    send_item(64'h8000_0000_0000_0000, 0, 0);          // -0 then +0: keep -0
    send_item(64'h0000_0000_0000_0000, 0, 0);
    send_item(dctp_pkg::ONE_BITS, 1, 0);               // boolean column
    send_item(64'h0000_0000_0000_0001, 0, 0);          // subnormal
    send_item(64'h800F_FFFF_FFFF_FFFF, 1, 2);
    send_item(dctp_pkg::POS_INF_BITS, 0, 0);
    send_item(dctp_pkg::NEG_INF_BITS, 0, 0);
    send_item(64'h7FEF_FFFF_FFFF_FFFF, 0, 0);          // largest finite
    send_item(64'hFFEF_FFFF_FFFF_FFFF, 0, 0);
    send_item(64'h4330_0000_0000_0001, 0, 0);          // 2^52 + 1, whole
    send_item(64'h4320_0000_0000_0001, 0, 0);          // 2^51 + 0.5
    send_item(64'h7FF0_0000_0000_0001, 1, 0);          // NaN on last
    send_item(64'h4000_0000_0000_0000, 0, 0);          // 2.0: whole, not bool
    send_item(64'h3FE0_0000_0000_0000, 1, 0);          // 0.5
    send_item(64'h0000_0000_0000_0000, 0, 0);
    send_item(64'h8000_0000_0000_0000, 1, 0);          // +0 then -0: keep +0

    // Random columns, mostly short; a few long ones.
    sent = 0;
    while (sent < 1900) begin
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (sent > 600 && !hold_done) begin
        hold_off_req = 1;
        hold_done = 1;
      end
      send_column(len);
      sent += len;
      if (sent > 1200 && !drained) begin
        // Pause until every pending result has drained.
        drained = 1;
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
